/* sv/rcm_pkg.sv */
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types and constants for the RTP CSRC matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package rcm_pkg;

  localparam int unsigned SlotRegs = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CsrcW    = 32;
  localparam int unsigned SlotW    = 3;
  localparam int unsigned PosW     = 7;
  localparam int unsigned CcW      = 4;

  localparam logic [7:0]         CcMask        = 8'h0f;
  localparam logic [PosW-1:0]    CsrcFirstByte = 7'd12;
  localparam logic [PosW-1:0]    PosMax        = 7'd127;

  localparam logic [CfgIdxW-1:0] CfgSlotBase   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEnableMask = 3'd6;

  typedef struct packed {
    logic             done;
    logic [CsrcW-1:0] word;
  } rcm_word_t;

  typedef struct packed {
    logic             hit;
    logic [CsrcW-1:0] csrc;
    logic [SlotW-1:0] slot;
  } rcm_result_t;

endpackage

`default_nettype wire

/* sv/rcm_cfg_regs.sv */
// ----------------------------------------------------------------------------
// rcm_cfg_regs
// Holds the CSRC slot identifiers and the slot enable mask.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_cfg_regs
  import rcm_pkg::*;
#(
  parameter int unsigned NUM_CMP = 6
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CsrcW-1:0]     cfg_data_i,
  output logic [NUM_CMP-1:0][CsrcW-1:0] slot_o,
  output logic [NUM_CMP-1:0]        enable_o
);

  logic [NUM_CMP-1:0][CsrcW-1:0] slot_q;
  logic [NUM_CMP-1:0]            enable_q;

  for (genvar k = 0; k < NUM_CMP; k++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[k] <= '0;
      end else if (cfg_valid_i && (cfg_index_i == CfgSlotBase + CfgIdxW'(k))) begin
        slot_q[k] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i == CfgEnableMask)) begin
      enable_q <= cfg_data_i[NUM_CMP-1:0];
    end
  end

  assign slot_o   = slot_q;
  assign enable_o = enable_q;

endmodule

`default_nettype wire

/* sv/rcm_byte_tracker.sv */
// ----------------------------------------------------------------------------
// rcm_byte_tracker
// Follows the byte position and CSRC count and assembles each CSRC word.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_byte_tracker
  import rcm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] pkt_byte_i,
  input  wire logic       start_of_packet_i,
  output rcm_word_t       word_o
);

  logic [PosW-1:0] pos_q, pos_d, pos_cur;
  logic [CcW-1:0]  cc_q, cc_d;
  logic [23:0]     shift_q, shift_d;
  logic [PosW-1:0] list_end;
  logic            in_list;

  always_comb begin
    pos_cur  = start_of_packet_i ? '0 : pos_q;
    cc_d     = (pos_cur == '0) ? CcW'(pkt_byte_i & CcMask) : cc_q;
    list_end = CsrcFirstByte + {1'b0, cc_d, 2'b00};
    in_list  = (pos_cur >= CsrcFirstByte) && (pos_cur < list_end);
    shift_d  = in_list ? {shift_q[15:0], pkt_byte_i} : shift_q;
    pos_d    = (pos_cur == PosMax) ? PosMax : pos_cur + PosW'(1);
    word_o.done = in_list && (pos_cur[1:0] == 2'b11);
    word_o.word = {shift_q, pkt_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      cc_q    <= '0;
      shift_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      cc_q    <= cc_d;
      shift_q <= shift_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rcm_slot_match.sv */
// ----------------------------------------------------------------------------
// rcm_slot_match
// Compares a completed CSRC word with the enabled slots, lowest slot first.
// ----------------------------------------------------------------------------
`default_nettype none

module rcm_slot_match
  import rcm_pkg::*;
#(
  parameter int unsigned NUM_CMP = 6
) (
  input  wire rcm_word_t                word_i,
  input  wire logic [NUM_CMP-1:0][CsrcW-1:0] slot_i,
  input  wire logic [NUM_CMP-1:0]       enable_i,
  output rcm_result_t                   result_o
);

  logic [NUM_CMP-1:0] eq;

  always_comb begin
    for (int k = 0; k < NUM_CMP; k++) begin
      eq[k] = enable_i[k] && (slot_i[k] == word_i.word);
    end
    result_o.hit  = word_i.done && (eq != '0);
    result_o.csrc = word_i.word;
    result_o.slot = '0;
    for (int k = NUM_CMP - 1; k >= 0; k--) begin
      if (eq[k]) begin
        result_o.slot = SlotW'(k);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/rtp_csrc_matcher_core.sv */
// ----------------------------------------------------------------------------
// rtp_csrc_matcher_core
// Reports registered contributing source ids found in RTP packet bytes.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle, with no gaps needed between
// beats. When the fourth byte of a CSRC word is accepted, the word is compared
// with every enabled slot in the same cycle; a match is registered into the
// two-entry output buffer (output register, then skid entry), so input beats
// keep flowing while one result waits to be taken; the input stalls only when
// both entries are full. Configuration writes are always accepted.
`default_nettype none

module rtp_csrc_matcher_core
  import rcm_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         pkt_byte_i,
  input  wire logic               start_of_packet_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [CsrcW-1:0]        matched_csrc_o,
  output logic [SlotW-1:0]        match_slot_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CsrcW-1:0]   cfg_data_i
);

  localparam int unsigned NumCmp = (NUM_SLOTS < SlotRegs) ? NUM_SLOTS : SlotRegs;

  logic [NumCmp-1:0][CsrcW-1:0] slot;
  logic [NumCmp-1:0]            enable;
  rcm_word_t                    word;
  rcm_result_t                  result;
  logic                         accept;
  logic                         push;
  logic                         out_valid_q;
  logic                         skid_valid_q;
  logic [CsrcW-1:0]             out_csrc_q, skid_csrc_q;
  logic [SlotW-1:0]             out_slot_q, skid_slot_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign push        = accept && result.hit;

  rcm_cfg_regs #(
    .NUM_CMP(NumCmp)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .slot_o     (slot),
    .enable_o   (enable)
  );

  rcm_byte_tracker u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .pkt_byte_i       (pkt_byte_i),
    .start_of_packet_i(start_of_packet_i),
    .word_o           (word)
  );

  rcm_slot_match #(
    .NUM_CMP(NumCmp)
  ) u_match (
    .word_i  (word),
    .slot_i  (slot),
    .enable_i(enable),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_csrc_q  <= skid_csrc_q;
        out_slot_q  <= skid_slot_q;
        skid_csrc_q <= result.csrc;
        skid_slot_q <= result.slot;
      end else begin
        out_csrc_q  <= result.csrc;
        out_slot_q  <= result.slot;
      end
    end else if (push) begin
      skid_csrc_q <= result.csrc;
      skid_slot_q <= result.slot;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign matched_csrc_o = out_csrc_q;
  assign match_slot_o   = out_slot_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("Skid entry held while output register is empty.");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_slot_q < SlotW'(NumCmp)))
    else $error("Reported slot is outside the compared range.");

  a_match_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
    else $error("Match into an empty buffer did not reach the output.");

  a_stall_keeps_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_ready_i) |=> (skid_valid_q && $stable(skid_csrc_q)))
    else $error("Buffered match lost during output stall.");

endmodule

`default_nettype wire
